/* rtl/core/dmm_pkg.sv */
// ----------------------------------------------------------------------------
// dmm_pkg
// Shared types and constants for the dense matrix multiply block: field
// widths, function and register codes, sequencer states and the issue tag.
// ----------------------------------------------------------------------------
package dmm_pkg;

   // Default sizes of the local stores and the element width
   localparam int DEF_MAX_ROWS   = 8;
   localparam int DEF_MAX_COLS   = 8;
   localparam int DEF_MAX_INNER  = 64;
   localparam int DEF_DATA_WIDTH = 16;

   // Fixed field widths
   localparam int FUNC_W  = 2;
   localparam int INDEX_W = 9;
   localparam int CVAL_W  = 40;
   localparam int ROW_W   = 3;
   localparam int COL_W   = 3;

   // Configuration registers
   localparam int CFG_ROWS_W  = 4;
   localparam int CFG_COLS_W  = 4;
   localparam int CFG_INNER_W = 7;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 7;

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER = 2'd2;

   localparam logic [CFG_ROWS_W-1:0]  RST_ROWS  = 4'd8;
   localparam logic [CFG_COLS_W-1:0]  RST_COLS  = 4'd8;
   localparam logic [CFG_INNER_W-1:0] RST_INNER = 7'd64;

   // Item functions
   localparam logic [FUNC_W-1:0] FN_LOAD_A  = 2'd0;
   localparam logic [FUNC_W-1:0] FN_LOAD_B  = 2'd1;
   localparam logic [FUNC_W-1:0] FN_COMPUTE = 2'd2;

   // Sequencer states
   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } dmm_state_type;

   // Tag that travels with each issued multiply-accumulate
   typedef struct packed {
      logic             first;   // first inner step of an element
      logic             last_t;  // last inner step of an element
      logic             fin;     // last element of the run
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
   } dmm_tag_type;

endpackage

/* rtl/core/dmm_channels.sv */
// ----------------------------------------------------------------------------
// dmm_channels
// Valid/ready channels of the dense matrix multiply block: request items
// (loads and compute) and result items (one per element of C).
// ----------------------------------------------------------------------------
interface dmm_req_if #(
   parameter int DATA_WIDTH = dmm_pkg::DEF_DATA_WIDTH
) ();
   import dmm_pkg::*;

   logic                         valid;
   logic                         ready;
   logic [FUNC_W-1:0]            func;
   logic [INDEX_W-1:0]           index;
   logic signed [DATA_WIDTH-1:0] value;

   modport source (output valid, func, index, value, input ready);
   modport sink   (input valid, func, index, value, output ready);
endinterface

interface dmm_rsp_if ();
   import dmm_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [CVAL_W-1:0] c_value;
   logic [ROW_W-1:0]         c_row;
   logic [COL_W-1:0]         c_col;
   logic                     last;

   modport source (output valid, c_value, c_row, c_col, last, input ready);
   modport sink   (input valid, c_value, c_row, c_col, last, output ready);
endinterface

/* rtl/core/dense_matrix_multiply.sv */
// ----------------------------------------------------------------------------
// dense_matrix_multiply
// C = A * B over column-major matrices held in two local RAMs. Load items
// write single elements of A or B; a compute item emits every element of C
// as a full-precision dot product, column by column, last one marked.
//
//   channel  dir  handshake          payload
//   req_if   in   valid/ready        func, index, value
//   rsp_if   out  valid/ready        c_value, c_row, c_col, last
//   csr      in   csr_we (no ready)  csr_index, csr_wdata
//
// Load items are taken one per cycle while no compute run is active. A
// compute item issues one read pair per cycle from the A and B RAMs while
// the pipeline advances, rows_m*cols_n*inner_k pairs in all; req ready
// returns once the last read pair is issued. The read, multiply and
// accumulate pipeline freezes while a result waits in the output register.
// Reset is synchronous; the RAMs are not cleared.
// ----------------------------------------------------------------------------
module dense_matrix_multiply #(
   parameter int MAX_ROWS   = dmm_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS   = dmm_pkg::DEF_MAX_COLS,
   parameter int MAX_INNER  = dmm_pkg::DEF_MAX_INNER,
   parameter int DATA_WIDTH = dmm_pkg::DEF_DATA_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   dmm_req_if.sink                         req_if,
   dmm_rsp_if.source                       rsp_if,
   input  logic                            csr_we,
   input  logic [dmm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dmm_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import dmm_pkg::*;

   localparam int MU_W    = $clog2(MAX_ROWS + 1);
   localparam int NU_W    = $clog2(MAX_COLS + 1);
   localparam int KU_W    = $clog2(MAX_INNER + 1);
   localparam int A_DEPTH = MAX_ROWS * MAX_INNER;
   localparam int B_DEPTH = MAX_INNER * MAX_COLS;
   localparam int A_AW    = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
   localparam int B_AW    = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
   localparam int LIM_W   = MU_W + KU_W + NU_W;
   localparam int CMP_W   = (LIM_W > INDEX_W) ? LIM_W : INDEX_W;
   localparam int AEXT_W  = (A_AW > INDEX_W) ? A_AW : INDEX_W;
   localparam int BEXT_W  = (B_AW > INDEX_W) ? B_AW : INDEX_W;
   localparam int PROD_W  = 2 * DATA_WIDTH;

   // Configuration registers
   logic [CFG_ROWS_W-1:0]  rows_ff;
   logic [CFG_COLS_W-1:0]  cols_ff;
   logic [CFG_INNER_W-1:0] inner_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff  <= RST_ROWS;
         cols_ff  <= RST_COLS;
         inner_ff <= RST_INNER;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ROWS:  rows_ff  <= csr_wdata[CFG_ROWS_W-1:0];
            CSR_COLS:  cols_ff  <= csr_wdata[CFG_COLS_W-1:0];
            CSR_INNER: inner_ff <= csr_wdata[CFG_INNER_W-1:0];
            default: ;
         endcase
      end
   end

   // Sizes in use: zero counts as one, oversize as the maximum
   logic [MU_W-1:0] m_use;
   logic [NU_W-1:0] n_use;
   logic [KU_W-1:0] k_use;

   always_comb begin
      priority if (rows_ff == '0)            m_use = MU_W'(1);
      else if (32'(rows_ff) > MAX_ROWS)      m_use = MU_W'(MAX_ROWS);
      else                                   m_use = MU_W'(rows_ff);
      priority if (cols_ff == '0)            n_use = NU_W'(1);
      else if (32'(cols_ff) > MAX_COLS)      n_use = NU_W'(MAX_COLS);
      else                                   n_use = NU_W'(cols_ff);
      priority if (inner_ff == '0)           k_use = KU_W'(1);
      else if (32'(inner_ff) > MAX_INNER)    k_use = KU_W'(MAX_INNER);
      else                                   k_use = KU_W'(inner_ff);
   end

   // Request decode and load writes
   logic                 req_accept;
   logic                 seq_busy;
   logic [LIM_W-1:0]     a_lim, b_lim;
   logic [AEXT_W-1:0]    a_idx_ext;
   logic [BEXT_W-1:0]    b_idx_ext;
   logic                 a_we, b_we, start;

   assign req_if.ready = !seq_busy;
   assign req_accept   = req_if.valid && req_if.ready;
   assign a_lim        = LIM_W'(m_use) * LIM_W'(k_use);
   assign b_lim        = LIM_W'(k_use) * LIM_W'(n_use);
   assign a_idx_ext    = AEXT_W'(req_if.index);
   assign b_idx_ext    = BEXT_W'(req_if.index);

   always_comb begin
      a_we  = 1'b0;
      b_we  = 1'b0;
      start = 1'b0;
      if (req_accept) begin
         unique case (req_if.func)
            FN_LOAD_A:  a_we  = (CMP_W'(req_if.index) < CMP_W'(a_lim));
            FN_LOAD_B:  b_we  = (CMP_W'(req_if.index) < CMP_W'(b_lim));
            FN_COMPUTE: start = 1'b1;
            default: ;
         endcase
      end
   end

   // Pipeline advances unless a result is stuck in the output register
   logic rsp_valid_ff;
   logic adv;

   assign adv = !rsp_valid_ff || rsp_if.ready;

   // Sequencer
   logic         issue;
   dmm_tag_type  s0_tag;
   logic [A_AW-1:0] a_raddr;
   logic [B_AW-1:0] b_raddr;

   dmm_seq #(
      .MAX_ROWS  (MAX_ROWS),
      .MAX_COLS  (MAX_COLS),
      .MAX_INNER (MAX_INNER)
   ) u_seq (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .adv     (adv),
      .m_use   (m_use),
      .n_use   (n_use),
      .k_use   (k_use),
      .busy    (seq_busy),
      .issue   (issue),
      .tag     (s0_tag),
      .a_raddr (a_raddr),
      .b_raddr (b_raddr)
   );

   // Element stores
   logic [DATA_WIDTH-1:0] a_rdata, b_rdata;

   dmm_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (A_DEPTH)
   ) u_a_ram (
      .clock   (clock),
      .wr_en   (a_we),
      .wr_addr (a_idx_ext[A_AW-1:0]),
      .wr_data (req_if.value),
      .rd_en   (issue),
      .rd_addr (a_raddr),
      .rd_data (a_rdata)
   );

   dmm_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (B_DEPTH)
   ) u_b_ram (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr (b_idx_ext[B_AW-1:0]),
      .wr_data (req_if.value),
      .rd_en   (issue),
      .rd_addr (b_raddr),
      .rd_data (b_rdata)
   );

   // Stage 1: read data valid; stage 2: product registered
   logic                     s1_valid_ff, s2_valid_ff;
   dmm_tag_type              s1_tag_ff, s2_tag_ff;
   logic signed [PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= issue;
         s2_valid_ff <= s1_valid_ff;
      end
      if (adv) begin
         s1_tag_ff <= s0_tag;
         s2_tag_ff <= s1_tag_ff;
         prod_ff   <= $signed(a_rdata) * $signed(b_rdata);
      end
   end

   // Accumulate; first inner step starts a fresh sum
   logic signed [CVAL_W-1:0] acc_ff;
   logic signed [CVAL_W-1:0] prod_ext;
   logic signed [CVAL_W-1:0] acc_in;

   assign prod_ext = CVAL_W'(prod_ff);
   assign acc_in   = (s2_tag_ff.first ? '0 : acc_ff) + prod_ext;

   always_ff @(posedge clock) begin
      if (adv && s2_valid_ff) begin
         acc_ff <= acc_in;
      end
   end

   // Output register
   logic signed [CVAL_W-1:0] rsp_value_ff;
   logic [ROW_W-1:0]         rsp_row_ff;
   logic [COL_W-1:0]         rsp_col_ff;
   logic                     rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= s2_valid_ff && s2_tag_ff.last_t;
      end
      if (adv) begin
         rsp_value_ff <= acc_in;
         rsp_row_ff   <= s2_tag_ff.row;
         rsp_col_ff   <= s2_tag_ff.col;
         rsp_last_ff  <= s2_tag_ff.fin;
      end
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.c_value = rsp_value_ff;
   assign rsp_if.c_row   = rsp_row_ff;
   assign rsp_if.c_col   = rsp_col_ff;
   assign rsp_if.last    = rsp_last_ff;

   // Checks
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> seq_busy)
      else $error("compute item did not start the sequencer");

   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      (a_we || b_we) |-> !seq_busy)
      else $error("store written while a compute run is reading");

   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(acc_ff) && $stable(s2_valid_ff) && $stable(s1_valid_ff))
      else $error("pipeline moved while the result register was stalled");

endmodule

/* rtl/core/dmm_ram.sv */
// ----------------------------------------------------------------------------
// dmm_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while the read enable is low.
// ----------------------------------------------------------------------------
module dmm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 512,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/dmm_seq.sv */
// ----------------------------------------------------------------------------
// dmm_seq
// Compute sequencer: walks C in column-major order and, for each element,
// the inner dimension, issuing one tagged A/B read pair per cycle while
// adv is high. Addresses are running sums, so no multiplier is needed.
// ----------------------------------------------------------------------------
module dmm_seq #(
   parameter int MAX_ROWS  = dmm_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS  = dmm_pkg::DEF_MAX_COLS,
   parameter int MAX_INNER = dmm_pkg::DEF_MAX_INNER,
   localparam int MU_W     = $clog2(MAX_ROWS + 1),
   localparam int NU_W     = $clog2(MAX_COLS + 1),
   localparam int KU_W     = $clog2(MAX_INNER + 1),
   localparam int A_DEPTH  = MAX_ROWS * MAX_INNER,
   localparam int B_DEPTH  = MAX_INNER * MAX_COLS,
   localparam int A_AW     = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1,
   localparam int B_AW     = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                adv,
   input  logic [MU_W-1:0]     m_use,
   input  logic [NU_W-1:0]     n_use,
   input  logic [KU_W-1:0]     k_use,
   output logic                busy,
   output logic                issue,
   output dmm_pkg::dmm_tag_type tag,
   output logic [A_AW-1:0]     a_raddr,
   output logic [B_AW-1:0]     b_raddr
);
   import dmm_pkg::*;

   dmm_state_type state_ff, state_in;

   logic [KU_W-1:0]  t_ff, t_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [A_AW-1:0]  a_addr_ff, a_addr_in;
   logic [B_AW-1:0]  b_addr_ff, b_addr_in;
   logic [B_AW-1:0]  b_base_ff, b_base_in;

   logic last_t, last_row, last_col, step;

   assign last_t   = (t_ff == KU_W'(k_use - KU_W'(1)));
   assign last_row = (row_ff == ROW_W'(m_use - MU_W'(1)));
   assign last_col = (col_ff == COL_W'(n_use - NU_W'(1)));
   assign step     = (state_ff == ST_RUN) && adv;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (start) state_in = ST_RUN;
         ST_RUN:  if (step && last_t && last_row && last_col) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      busy       = (state_ff == ST_RUN);
      issue      = step;
      tag.first  = (t_ff == '0);
      tag.last_t = last_t;
      tag.fin    = last_t && last_row && last_col;
      tag.row    = row_ff;
      tag.col    = col_ff;
      a_raddr    = a_addr_ff;
      b_raddr    = b_addr_ff;
   end

   // Loop counters and running addresses
   always_comb begin
      t_in      = t_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      a_addr_in = a_addr_ff;
      b_addr_in = b_addr_ff;
      b_base_in = b_base_ff;
      if (start && (state_ff == ST_IDLE)) begin
         t_in      = '0;
         row_in    = '0;
         col_in    = '0;
         a_addr_in = '0;
         b_addr_in = '0;
         b_base_in = '0;
      end else if (step) begin
         if (!last_t) begin
            // next inner step: A moves one column, B one row
            t_in      = t_ff + KU_W'(1);
            a_addr_in = a_addr_ff + A_AW'(m_use);
            b_addr_in = b_addr_ff + B_AW'(1);
         end else if (!last_row) begin
            // next row of the same column
            t_in      = '0;
            row_in    = row_ff + ROW_W'(1);
            a_addr_in = A_AW'(row_ff) + A_AW'(1);
            b_addr_in = b_base_ff;
         end else begin
            // next column
            t_in      = '0;
            row_in    = '0;
            col_in    = col_ff + COL_W'(1);
            a_addr_in = '0;
            b_base_in = b_base_ff + B_AW'(k_use);
            b_addr_in = b_base_ff + B_AW'(k_use);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      t_ff      <= t_in;
      row_ff    <= row_in;
      col_ff    <= col_in;
      a_addr_ff <= a_addr_in;
      b_addr_ff <= b_addr_in;
      b_base_ff <= b_base_in;
   end

endmodule

/* tb/sv/dense_matrix_multiply_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dense_matrix_multiply_checker
// Watches the request, result and register ports of the matrix multiply
// block, keeps its own copy of the A and B stores and the sizes, works out
// every C element of each compute item and checks the results in order.
// ----------------------------------------------------------------------------
module dense_matrix_multiply_checker (
   input  logic                            clock,
   input  logic                            reset,
   dmm_req_if                              req_mon,
   dmm_rsp_if                              rsp_mon,
   input  logic                            csr_we,
   input  logic [dmm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dmm_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                              mismatches,
   output int                              pending,
   output int                              elements_seen
);
   import dmm_pkg::*;

   localparam int A_DEPTH = DEF_MAX_ROWS * DEF_MAX_INNER;
   localparam int B_DEPTH = DEF_MAX_INNER * DEF_MAX_COLS;

   typedef struct {
      logic signed [CVAL_W-1:0] c_value;
      logic [ROW_W-1:0]         row;
      logic [COL_W-1:0]         col;
      logic                     last;
   } c_elem_type;

   // local copy of the stores and the size registers
   logic signed [DEF_DATA_WIDTH-1:0] a_elems [0:A_DEPTH-1];
   logic signed [DEF_DATA_WIDTH-1:0] b_elems [0:B_DEPTH-1];
   logic [CFG_ROWS_W-1:0]            rows_cfg;
   logic [CFG_COLS_W-1:0]            cols_cfg;
   logic [CFG_INNER_W-1:0]           inner_cfg;

   c_elem_type c_due[$];
   c_elem_type want;
   c_elem_type got;
   int      m, n, k, col, row, t;
   longint  dot;
   int      bad_count = 0;
   int      seen_count = 0;

   // zero counts as one, anything above the store size as the store size
   function automatic int clamp_dim(int raw, int limit);
      if (raw == 0)
         return 1;
      if (raw > limit)
         return limit;
      return raw;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rows_cfg  = RST_ROWS;
         cols_cfg  = RST_COLS;
         inner_cfg = RST_INNER;
         c_due.delete();
      end else begin
         m = clamp_dim(int'(rows_cfg), DEF_MAX_ROWS);
         n = clamp_dim(int'(cols_cfg), DEF_MAX_COLS);
         k = clamp_dim(int'(inner_cfg), DEF_MAX_INNER);

         // result side: compare with the oldest element still due
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.c_value = rsp_mon.c_value;
            got.row     = rsp_mon.c_row;
            got.col     = rsp_mon.c_col;
            got.last    = rsp_mon.last;
            seen_count++;
            if (c_due.size() == 0) begin
               bad_count++;
               if (bad_count <= 10)
                  $display("C element %0d arrived unasked: value %0d row %0d col %0d last %0b",
                           seen_count, got.c_value, got.row, got.col, got.last);
            end else begin
               want = c_due.pop_front();
               if (got.c_value !== want.c_value || got.row !== want.row ||
                   got.col !== want.col || got.last !== want.last) begin
                  bad_count++;
                  if (bad_count <= 10)
                     $display({"C element %0d differs: expected value %0d row %0d col %0d ",
                               "last %0b, got value %0d row %0d col %0d last %0b"},
                              seen_count, want.c_value, want.row, want.col, want.last,
                              got.c_value, got.row, got.col, got.last);
               end
            end
         end

         // request side: loads update the stores, compute queues all of C
         if (req_mon.valid && req_mon.ready) begin
            case (req_mon.func)
               FN_LOAD_A: begin
                  if (int'(req_mon.index) < m * k)
                     a_elems[req_mon.index] = req_mon.value;
               end
               FN_LOAD_B: begin
                  if (int'(req_mon.index) < k * n)
                     b_elems[req_mon.index] = req_mon.value;
               end
               FN_COMPUTE: begin
                  for (col = 0; col < n; col++) begin
                     for (row = 0; row < m; row++) begin
                        dot = 0;
                        for (t = 0; t < k; t++)
                           dot += longint'(a_elems[t * m + row]) *
                                  longint'(b_elems[col * k + t]);
                        want.c_value = dot[CVAL_W-1:0];
                        want.row     = row[ROW_W-1:0];
                        want.col     = col[COL_W-1:0];
                        want.last    = (col == n - 1) && (row == m - 1);
                        c_due.push_back(want);
                     end
                  end
               end
               default: ;
            endcase
         end

         // register writes take effect for later items
         if (csr_we) begin
            case (csr_index)
               CSR_ROWS:  rows_cfg  = csr_wdata[CFG_ROWS_W-1:0];
               CSR_COLS:  cols_cfg  = csr_wdata[CFG_COLS_W-1:0];
               CSR_INNER: inner_cfg = csr_wdata[CFG_INNER_W-1:0];
               default: ;
            endcase
         end
      end
      mismatches    <= bad_count;
      pending       <= c_due.size();
      elements_seen <= seen_count;
   end

endmodule

/* tb/sv/dense_matrix_multiply_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dense_matrix_multiply_test
// Drives the matrix multiply block through a range of matrix sizes: loads of
// A and B in random order with out-of-range and unused items mixed in, then
// compute items, with random gaps on the request side and stalls on the
// result side. A checker beside the block predicts and compares each C item.
// ----------------------------------------------------------------------------
module dense_matrix_multiply_test;
   import dmm_pkg::*;

   localparam int LIMIT_CYCLES = 400000;
   localparam int DRAIN_CYCLES = 100;
   localparam int STORE_DEPTH  = DEF_MAX_ROWS * DEF_MAX_INNER;

   // codes the block leaves unused
   localparam logic [FUNC_W-1:0]    FN_SPARE  = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef enum int {
      VAL_RANDOM,
      VAL_PEAK_POS,   // every element full-scale negative: largest sum
      VAL_PEAK_NEG,   // A full-scale negative, B full-scale positive
      VAL_EDGES
   } fill_mode_type;

   typedef struct {
      logic [FUNC_W-1:0]                func;
      logic [INDEX_W-1:0]               index;
      logic signed [DEF_DATA_WIDTH-1:0] value;
   } req_item_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   dmm_req_if req_ch ();
   dmm_rsp_if rsp_ch ();

   int mismatches;
   int pending;
   int elements_seen;
   int cycle_count = 0;
   int stall_left  = 0;
   int n_loads     = 0;
   int n_ignored   = 0;
   int n_computes  = 0;
   int n_settings  = 0;
   int n_random    = 0;
   bit quiet       = 1'b0;
   bit a_written [0:STORE_DEPTH-1];
   bit b_written [0:STORE_DEPTH-1];

   dense_matrix_multiply DUT (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   dense_matrix_multiply_checker product_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .mismatches    (mismatches),
      .pending       (pending),
      .elements_seen (elements_seen)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // cycle limit
   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= LIMIT_CYCLES);
      $display("Cycle limit reached with %0d C elements still due", pending);
      $display("Regression FAIL");
      $finish;
   end

   // result side: random stall bursts, none once quiet
   always @(negedge clock) begin
      if (quiet) begin
         stall_left = 0;
         rsp_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 17);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // one request item, with a random gap ahead of it
   task automatic send_item(logic [FUNC_W-1:0] func, logic [INDEX_W-1:0] index,
                            logic signed [DEF_DATA_WIDTH-1:0] value);
      int gap;
      gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.func  <= func;
      req_ch.index <= index;
      req_ch.value <= value;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // drop valid, wait for every C element, then let the pipeline settle
   task automatic drain();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // register code for a size: sometimes zero for one, or above the maximum
   function automatic logic [CSR_DATA_W-1:0] reg_code(int eff, int maxv, int width);
      int field;
      int mask;
      mask  = (1 << width) - 1;
      field = eff;
      if (eff == 1 && $urandom_range(0, 2) == 0)
         field = 0;
      else if (eff == maxv && maxv < mask && $urandom_range(0, 1) == 0)
         field = $urandom_range(maxv + 1, mask);
      return CSR_DATA_W'((int'($urandom) & ~mask) | field);
   endfunction

   function automatic logic signed [DEF_DATA_WIDTH-1:0] pick_value(fill_mode_type mode,
                                                                   bit for_b);
      case (mode)
         VAL_PEAK_POS: return 16'sh8000;
         VAL_PEAK_NEG: return for_b ? 16'sh7FFF : 16'sh8000;
         VAL_EDGES: begin
            case ($urandom_range(0, 4))
               0:       return 16'sh8000;
               1:       return 16'sh7FFF;
               2:       return 16'shFFFF;
               3:       return 16'sh0000;
               default: return 16'sh0001;
            endcase
         end
         default: return DEF_DATA_WIDTH'($urandom);
      endcase
   endfunction

   // program the sizes, fill every entry the compute reads, then compute
   task automatic run_setting(int m, int n, int k, fill_mode_type mode, int computes);
      logic [CSR_IDX_W-1:0] order [3];
      logic [CSR_IDX_W-1:0] swap_idx;
      req_item_type         it;
      req_item_type         swap_item;
      req_item_type         load_q [$];
      int                   j, r, lim_a, lim_b;
      drain();
      order = '{CSR_ROWS, CSR_COLS, CSR_INNER};
      for (j = 2; j > 0; j--) begin
         r        = $urandom_range(0, j);
         swap_idx = order[j];
         order[j] = order[r];
         order[r] = swap_idx;
      end
      for (j = 0; j < 3; j++) begin
         case (order[j])
            CSR_ROWS: csr_write(CSR_ROWS, reg_code(m, DEF_MAX_ROWS, CFG_ROWS_W));
            CSR_COLS: csr_write(CSR_COLS, reg_code(n, DEF_MAX_COLS, CFG_COLS_W));
            default:  csr_write(CSR_INNER, reg_code(k, DEF_MAX_INNER, CFG_INNER_W));
         endcase
      end
      if ($urandom_range(0, 3) == 0)
         csr_write(CSR_SPARE, CSR_DATA_W'($urandom));
      n_settings++;

      // entries never written must be loaded; others are reloaded now and then
      lim_a = m * k;
      lim_b = k * n;
      for (j = 0; j < lim_a; j++) begin
         if (!a_written[j] || mode != VAL_RANDOM || $urandom_range(0, 3) == 0) begin
            it = '{FN_LOAD_A, INDEX_W'(j), pick_value(mode, 1'b0)};
            load_q.push_back(it);
            a_written[j] = 1'b1;
         end
      end
      for (j = 0; j < lim_b; j++) begin
         if (!b_written[j] || mode != VAL_RANDOM || $urandom_range(0, 3) == 0) begin
            it = '{FN_LOAD_B, INDEX_W'(j), pick_value(mode, 1'b1)};
            load_q.push_back(it);
            b_written[j] = 1'b1;
         end
      end
      n_loads  += load_q.size();
      n_random += load_q.size();

      // loads past the sizes in use and the unused function
      repeat ($urandom_range(0, 3)) begin
         r = $urandom_range(0, 2);
         if (r == 0 && lim_a < STORE_DEPTH)
            it = '{FN_LOAD_A, INDEX_W'($urandom_range(lim_a, STORE_DEPTH - 1)),
                   DEF_DATA_WIDTH'($urandom)};
         else if (r == 1 && lim_b < STORE_DEPTH)
            it = '{FN_LOAD_B, INDEX_W'($urandom_range(lim_b, STORE_DEPTH - 1)),
                   DEF_DATA_WIDTH'($urandom)};
         else
            it = '{FN_SPARE, INDEX_W'($urandom), DEF_DATA_WIDTH'($urandom)};
         load_q.push_back(it);
         n_ignored++;
      end

      for (j = load_q.size() - 1; j > 0; j--) begin
         r         = $urandom_range(0, j);
         swap_item = load_q[j];
         load_q[j] = load_q[r];
         load_q[r] = swap_item;
      end
      foreach (load_q[j])
         send_item(load_q[j].func, load_q[j].index, load_q[j].value);

      // computes, some back to back, some after a few fresh loads
      for (j = 0; j < computes; j++) begin
         if (j > 0 && mode == VAL_RANDOM && $urandom_range(0, 1) == 0) begin
            repeat ($urandom_range(1, 4)) begin
               if ($urandom_range(0, 1) == 0)
                  send_item(FN_LOAD_A, INDEX_W'($urandom_range(0, lim_a - 1)),
                            DEF_DATA_WIDTH'($urandom));
               else
                  send_item(FN_LOAD_B, INDEX_W'($urandom_range(0, lim_b - 1)),
                            DEF_DATA_WIDTH'($urandom));
               n_loads++;
               n_random++;
            end
         end
         send_item(FN_COMPUTE, INDEX_W'($urandom), DEF_DATA_WIDTH'($urandom));
         n_computes++;
         n_random++;
      end
   endtask

   initial begin
      int m, n, k, j;
      fill_mode_type mode;

      req_ch.valid = 1'b0;
      req_ch.func  = FN_LOAD_A;
      req_ch.index = '0;
      req_ch.value = '0;
      rsp_ch.ready = 1'b0;
      csr_we       = 1'b0;
      csr_index    = CSR_ROWS;
      csr_wdata    = '0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // directed: 2x2x2 with full-scale and signed edge values
      csr_write(CSR_ROWS, 7'd2);
      csr_write(CSR_COLS, 7'd2);
      csr_write(CSR_INNER, 7'd2);
      n_settings++;
      send_item(FN_LOAD_A, 9'd0, 16'sh8000);
      send_item(FN_LOAD_B, 9'd0, 16'sh8000);
      send_item(FN_LOAD_A, 9'd1, 16'sh7FFF);
      send_item(FN_LOAD_B, 9'd1, 16'sh0001);
      send_item(FN_LOAD_A, 9'd2, 16'sh0000);
      send_item(FN_LOAD_B, 9'd2, 16'sh7FFF);
      send_item(FN_LOAD_A, 9'd3, 16'shFFFF);
      send_item(FN_LOAD_B, 9'd3, 16'sh8000);
      // out of range and unused function must leave the stores alone
      send_item(FN_LOAD_A, 9'd4, 16'sh1234);
      send_item(FN_LOAD_A, 9'd511, 16'sh5555);
      send_item(FN_LOAD_B, 9'd4, 16'sh4321);
      send_item(FN_LOAD_B, 9'd511, 16'shAAAA);
      send_item(FN_SPARE, 9'd0, 16'sh7FFF);
      send_item(FN_SPARE, 9'd511, 16'sh8000);
      send_item(FN_COMPUTE, 9'd0, 16'sh0000);
      send_item(FN_COMPUTE, 9'd511, 16'shFFFF);
      for (j = 0; j < 4; j++) begin
         a_written[j] = 1'b1;
         b_written[j] = 1'b1;
      end
      n_loads    += 8;
      n_ignored  += 6;
      n_computes += 2;

      // size extremes and full-scale sums
      run_setting(1, 1, 64, VAL_PEAK_POS, 1);
      run_setting(1, 1, 16, VAL_PEAK_NEG, 1);
      run_setting(8, 8, 1, VAL_EDGES, 2);
      run_setting(1, 1, 1, VAL_EDGES, 1);
      run_setting(8, 1, 2, VAL_RANDOM, 1);
      run_setting(1, 8, 3, VAL_RANDOM, 2);

      // random sizes, mostly small, stores reused across settings
      n_random = 0;
      while (n_random < 80) begin
         if (n_random >= 60)
            quiet = 1'b1;
         if ($urandom_range(0, 9) == 0) begin
            k = $urandom_range(9, 64);
            m = $urandom_range(1, 2);
            n = $urandom_range(1, 2);
         end else begin
            k = $urandom_range(1, 8);
            m = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 8);
            n = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 8);
         end
         mode = ($urandom_range(0, 5) == 0) ? VAL_EDGES : VAL_RANDOM;
         run_setting(m, n, k, mode, $urandom_range(1, 3));
      end

      drain();
      $display("Covered %0d loads, %0d ignored items and %0d computes over %0d size settings",
               n_loads, n_ignored, n_computes, n_settings);
      $display("Checked %0d C elements, %0d mismatches", elements_seen, mismatches);
      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
